FILE: sv/ddeod_pkg.sv
// Package for the deque with duplicate-checked back insert and two dump modes.
// Holds sizes, command and status codes, the control/status structs and index arithmetic.
// No dependencies.
`default_nettype none

package ddeod_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int VAL_W = 31;
	localparam int OP_W  = 2;
	localparam int ST_W  = 3;

	localparam logic [OP_W-1:0] OP_INS_FRONT  = 2'd0;
	localparam logic [OP_W-1:0] OP_INS_BACK   = 2'd1;
	localparam logic [OP_W-1:0] OP_DUMP_ORDER = 2'd2;
	localparam logic [OP_W-1:0] OP_DUMP_EVODD = 2'd3;

	localparam logic [ST_W-1:0] ST_DUMP   = 3'd0;
	localparam logic [ST_W-1:0] ST_STORED = 3'd1;
	localparam logic [ST_W-1:0] ST_NONPOS = 3'd2;
	localparam logic [ST_W-1:0] ST_DUP    = 3'd3;
	localparam logic [ST_W-1:0] ST_FULL   = 3'd4;
	localparam logic [ST_W-1:0] ST_EMPTY  = 3'd5;

	typedef struct packed {
		logic            accept;
		logic            rd;
		logic            pass2;
		logic            push;
		logic            flush;
		logic            resp;
		logic            wr_front;
		logic            wr_back;
		logic [ST_W-1:0] status;
	} ddeod_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            positive;
		logic            count_zero;
		logic            full;
		logic            walk_done;
		logic            match;
		logic            keep;
		logic            pass;
		logic            out_free;
	} ddeod_stat_t;

	function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = {{(CNT_W + 1 - IDX_W){1'b0}}, base} + {1'b0, off};
		if (sum >= (CNT_W + 1)'(DEPTH))
			sum = sum - (CNT_W + 1)'(DEPTH);
		return sum[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: sv/ddeod_dp.sv
// Datapath: entry store, front/count registers, walk counter, held entry and output word.
// Depends on ddeod_pkg; driven by ddeod_ctrl through ddeod_cmd_t.
`default_nettype none

module ddeod_dp (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  [31:0]              s_tdata,
	input  wire  [ddeod_pkg::OP_W-1:0] s_tuser,
	input  ddeod_pkg::ddeod_cmd_t    cmd,
	output ddeod_pkg::ddeod_stat_t   stat,
	output logic                     m_tvalid,
	input  wire                      m_tready,
	output logic [31:0]              m_tdata,
	output logic                     m_tlast,
	output logic [ddeod_pkg::ST_W-1:0] m_tuser
);
	import ddeod_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;
	logic [OP_W-1:0]  op_q;
	logic [VAL_W-1:0] val_q;
	logic             pos_q;
	logic [IDX_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] k_q;
	logic             pass_q;
	logic [VAL_W-1:0] held_q;
	logic             held_vld_q;
	logic             out_vld_q;
	logic [ST_W-1:0]  out_st_q;
	logic [VAL_W-1:0] out_val_q;
	logic             out_last_q;

	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;
	logic             out_free;
	logic             out_load;
	logic             full;

	assign front_dec = (front_q == '0) ? IDX_W'(DEPTH - 1) : front_q - 1'b1;
	assign wr_addr   = cmd.wr_front ? front_dec : wrap_add(front_q, count_q);
	assign rd_addr   = wrap_add(front_q, k_q);
	assign out_free  = !out_vld_q || m_tready;
	assign out_load  = (cmd.push && held_vld_q) || cmd.flush || cmd.resp;
	assign full      = (count_q == CNT_W'(DEPTH));

	always_ff @(posedge clk) begin
		if (cmd.wr_front || cmd.wr_back)
			mem[wr_addr] <= val_q;
		if (cmd.rd)
			rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q  <= s_tuser;
			val_q <= s_tdata[VAL_W-1:0];
			pos_q <= !s_tdata[31] && (s_tdata[30:0] != '0);
		end
		if (cmd.push)
			held_q <= rdata_q;
		if (cmd.resp) begin
			out_st_q   <= cmd.status;
			out_val_q  <= '0;
			out_last_q <= 1'b1;
		end else if (cmd.flush || (cmd.push && held_vld_q)) begin
			out_st_q   <= ST_DUMP;
			out_val_q  <= held_q;
			out_last_q <= cmd.flush;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q    <= '0;
			count_q    <= '0;
			k_q        <= '0;
			pass_q     <= 1'b0;
			held_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cmd.wr_front)
				front_q <= front_dec;
			if (cmd.wr_front || cmd.wr_back)
				count_q <= count_q + 1'b1;
			if (cmd.accept || cmd.pass2)
				k_q <= '0;
			else if (cmd.rd)
				k_q <= k_q + 1'b1;
			if (cmd.accept)
				pass_q <= 1'b0;
			else if (cmd.pass2)
				pass_q <= 1'b1;
			if (cmd.accept || cmd.flush)
				held_vld_q <= 1'b0;
			else if (cmd.push)
				held_vld_q <= 1'b1;
			if (out_load)
				out_vld_q <= 1'b1;
			else if (m_tready)
				out_vld_q <= 1'b0;
		end
	end

	always_comb begin
		stat.op         = op_q;
		stat.positive   = pos_q;
		stat.count_zero = (count_q == '0);
		stat.full       = full;
		stat.walk_done  = (k_q == count_q);
		stat.match      = (rdata_q == val_q);
		stat.keep       = (op_q == OP_DUMP_ORDER) || (rdata_q[0] == pass_q);
		stat.pass       = pass_q;
		stat.out_free   = out_free;
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_val_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_st_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count above depth");
	a_no_write_full: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.wr_front || cmd.wr_back) |-> !full)
		else $error("store write while full");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !m_tready) |-> !out_load)
		else $error("pending output word overwritten");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd |-> (k_q < count_q))
		else $error("read beyond stored entries");
`endif

endmodule

`default_nettype wire

FILE: sv/ddeod_ctrl.sv
// Controller: sequences accept, search walk, dump passes, store and response words.
// Depends on ddeod_pkg; commands ddeod_dp, reads its status.
`default_nettype none

module ddeod_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    s_tvalid,
	output logic                   s_tready,
	input  ddeod_pkg::ddeod_stat_t stat,
	output ddeod_pkg::ddeod_cmd_t  cmd
);
	import ddeod_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_READ   = 3'd2;
	localparam logic [2:0] S_CHECK  = 3'd3;
	localparam logic [2:0] S_STORE  = 3'd4;
	localparam logic [2:0] S_FLUSH  = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]      state_q;
	logic [2:0]      state_nxt;
	logic [ST_W-1:0] status_q;
	logic [ST_W-1:0] status_nxt;
	logic            status_ld;
	logic            is_dump;

	assign is_dump  = stat.op inside {OP_DUMP_ORDER, OP_DUMP_EVODD};
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_nxt  = state_q;
		status_nxt = ST_STORED;
		status_ld  = 1'b0;
		cmd        = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nxt  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (is_dump) begin
					if (stat.count_zero) begin
						status_nxt = ST_EMPTY;
						status_ld  = 1'b1;
						state_nxt  = S_RESP;
					end else begin
						state_nxt = S_READ;
					end
				end else if (!stat.positive) begin
					status_nxt = ST_NONPOS;
					status_ld  = 1'b1;
					state_nxt  = S_RESP;
				end else if (stat.op == OP_INS_BACK && !stat.count_zero) begin
					state_nxt = S_READ;
				end else begin
					state_nxt = S_STORE;
				end
			end
			S_READ: begin
				if (!is_dump || stat.out_free) begin
					cmd.rd    = 1'b1;
					state_nxt = S_CHECK;
				end
			end
			S_CHECK: begin
				if (!is_dump) begin
					if (stat.match) begin
						status_nxt = ST_DUP;
						status_ld  = 1'b1;
						state_nxt  = S_RESP;
					end else if (stat.walk_done) begin
						state_nxt = S_STORE;
					end else begin
						state_nxt = S_READ;
					end
				end else begin
					cmd.push = stat.keep;
					if (!stat.walk_done) begin
						state_nxt = S_READ;
					end else if (stat.op == OP_DUMP_EVODD && !stat.pass) begin
						cmd.pass2 = 1'b1;
						state_nxt = S_READ;
					end else begin
						state_nxt = S_FLUSH;
					end
				end
			end
			S_STORE: begin
				status_ld = 1'b1;
				state_nxt = S_RESP;
				if (stat.full) begin
					status_nxt = ST_FULL;
				end else begin
					status_nxt   = ST_STORED;
					cmd.wr_front = (stat.op == OP_INS_FRONT);
					cmd.wr_back  = (stat.op == OP_INS_BACK);
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.resp   = 1'b1;
					cmd.status = status_q;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (status_ld)
			status_q <= status_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/deque_dedup_even_odd_dump_top.sv
// Top level of the deque with duplicate-checked back insert and two dump modes.
// Depends on ddeod_pkg, ddeod_ctrl and ddeod_dp.
//
//   channel  dir  fields
//   s_*      in   tuser[1:0] op; tdata[31:0] value
//   m_*      out  tuser[2:0] status; tdata[30:0] entry_value; tlast last
//
// Insert back walks the stored entries in search of a duplicate; dump evens then odds walks
// the store twice, evens first. The walk reads each entry and checks it before the next read.
// Reset clears front position, count, walk and output state and the controller state; the store is not cleared.
// A stalled result word holds the walk; only one command is in flight.
`default_nettype none

module deque_dedup_even_odd_dump_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [31:0] s_tdata,  // [31:0] value
	input  wire [1:0]  s_tuser,  // [1:0] op
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [31:0] m_tdata, // [30:0] entry_value, [31] zero
	output logic [2:0] m_tuser,  // [2:0] status
	output logic       m_tlast
);
	import ddeod_pkg::*;

	ddeod_cmd_t  cmd;
	ddeod_stat_t stat;

	ddeod_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ddeod_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

`default_nettype wire
